/* hw/rtl/bmpc_pkg.sv */
package bmpc_pkg;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int PIDX_W  = 8;
  localparam int WORD_W  = 32;
  localparam int RADDR_W = 13;
  localparam int BYTE_W  = 8;
  localparam int X_W     = 11;
  localparam int FMT_W   = 2;
  localparam int SW_W    = 12;
  localparam int PCOL_W  = 9;

  // scaling datapath
  localparam int PROD_W         = X_W + SW_W;
  localparam int DIV_W          = 24;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = DIV_W / DIV_RADIX_BITS;
  localparam int ADDR_W         = DIV_W + 2;
  localparam int ROW_BANKS      = 4;

  // output buffer
  localparam int OFIFO_DEPTH = 32;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  // config port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_FORMAT     = 2'd0;
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_PAL_COLORS = 2'd3;

  localparam logic [WORD_W-1:0] OPAQUE      = 32'hFF00_0000;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] ALPHA_ZERO  = 8'h00;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PAL_WR  = 2'd0,
    FUNC_ROW_WR  = 2'd1,
    FUNC_PIX_REQ = 2'd2
  } func_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_4BPP  = 2'd0,
    FMT_8BPP  = 2'd1,
    FMT_24BPP = 2'd2,
    FMT_32BPP = 2'd3
  } fmt_e;

  typedef struct packed {
    func_e               func;
    logic [PIDX_W-1:0]   pidx;
    logic [WORD_W-1:0]   pword;
    logic [RADDR_W-1:0]  raddr;
    logic [BYTE_W-1:0]   rbyte;
    logic [X_W-1:0]      x;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] argb;
    logic [X_W-1:0]    x;
  } res_t;

  function automatic logic [WORD_W-1:0] fix_alpha(input logic [WORD_W-1:0] argb);
    logic [WORD_W-1:0] res;
    res = argb;
    if (argb[31:24] == ALPHA_ZERO) begin
      res = argb | OPAQUE;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/bmpc_ram.sv */
module bmpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bmpc_div.sv */
module bmpc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  bmpc_pkg::item_t               item_i,
  input  logic [bmpc_pkg::PROD_W-1:0]   prod_i,
  input  logic [bmpc_pkg::SW_W-1:0]     divisor_i,
  output logic                          vld_o,
  output bmpc_pkg::item_t               item_o,
  output logic [bmpc_pkg::DIV_W-1:0]    quot_o
);
  import bmpc_pkg::*;

  logic              vld_q  [DIV_STEPS];
  item_t             item_q [DIV_STEPS];
  logic [SW_W-1:0]   rem_q  [DIV_STEPS];
  logic [DIV_W-1:0]  nq_q   [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    logic              vld_in;
    item_t             item_in;
    logic [SW_W-1:0]   rem_in;
    logic [DIV_W-1:0]  nq_in;
    logic [SW_W-1:0]   rem_d;
    logic [DIV_W-1:0]  nq_d;
    logic [SW_W:0]     trial;
    logic [SW_W:0]     diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign item_in = item_i;
      assign rem_in  = '0;
      assign nq_in   = DIV_W'(prod_i);
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign item_in = item_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign nq_in   = nq_q[s-1];
    end

    // dividend bits shift out the top, quotient bits shift in at the bottom
    always_comb begin
      rem_d = rem_in;
      nq_d  = nq_in;
      trial = '0;
      diff  = '0;
      ge    = 1'b0;
      for (int b = 0; b < DIV_RADIX_BITS; b++) begin
        trial = {rem_d, nq_d[DIV_W-1]};
        diff  = trial - {1'b0, divisor_i};
        ge    = trial >= {1'b0, divisor_i};
        rem_d = ge ? diff[SW_W-1:0] : trial[SW_W-1:0];
        nq_d  = {nq_d[DIV_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      item_q[s] <= item_in;
      rem_q[s]  <= rem_d;
      nq_q[s]   <= nq_d;
    end
  end

  assign vld_o  = vld_q[DIV_STEPS-1];
  assign item_o = item_q[DIV_STEPS-1];
  assign quot_o = nq_q[DIV_STEPS-1];

endmodule

/* hw/rtl/bmpc_fetch.sv */
module bmpc_fetch #(
  parameter int MAX_ROW_BYTES = 8192,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  bmpc_pkg::item_t               item_i,
  input  logic [bmpc_pkg::DIV_W-1:0]    sx_i,
  input  bmpc_pkg::fmt_e                fmt_i,
  input  logic [bmpc_pkg::PCOL_W-1:0]   pal_colors_i,
  output logic                          res_vld_o,
  output bmpc_pkg::res_t                res_o
);
  import bmpc_pkg::*;

  localparam int BANK_DEPTH = (MAX_ROW_BYTES + ROW_BANKS - 1) / ROW_BANKS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int PAL_AW     = $clog2(PALETTE_DEPTH);
  localparam logic [ADDR_W:0]   ROW_LIMIT = (ADDR_W + 1)'(MAX_ROW_BYTES);
  localparam logic [PCOL_W-1:0] PAL_LIMIT = PCOL_W'(PALETTE_DEPTH);

  // stage a: byte address of the first source byte
  logic               vld_a_q;
  item_t              item_a_q;
  logic [ADDR_W-1:0]  addr_a_q;
  logic               nib_a_q;
  logic [ADDR_W-1:0]  addr_a_d;

  always_comb begin
    case (fmt_i)
      FMT_4BPP:  addr_a_d = ADDR_W'(sx_i >> 1);
      FMT_8BPP:  addr_a_d = ADDR_W'(sx_i);
      FMT_24BPP: addr_a_d = ADDR_W'({sx_i, 1'b0}) + ADDR_W'(sx_i);
      default:   addr_a_d = ADDR_W'({sx_i, 2'b00});
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_a_q <= item_i;
    addr_a_q <= addr_a_d;
    nib_a_q  <= sx_i[0];
  end

  // row store: four byte banks so any four consecutive bytes come out together
  logic [ADDR_W-1:0]     row_waddr;
  logic                  row_wr_ok;
  logic [ROW_BANKS-1:0]  rd_ok;
  logic [BYTE_W-1:0]     bank_rd [ROW_BANKS];

  assign row_waddr = ADDR_W'(item_a_q.raddr);
  assign row_wr_ok = vld_a_q && (item_a_q.func == FUNC_ROW_WR) &&
                     ({1'b0, row_waddr} < ROW_LIMIT);

  for (genvar b = 0; b < ROW_BANKS; b++) begin : g_bank
    logic [1:0]         ofs;
    logic [ADDR_W-1:0]  ea;
    logic               we;

    assign ofs      = 2'(b) - addr_a_q[1:0];
    assign ea       = addr_a_q + ADDR_W'(ofs);
    assign rd_ok[b] = {1'b0, ea} < ROW_LIMIT;
    assign we       = row_wr_ok && (row_waddr[1:0] == 2'(b));

    bmpc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
    ) u_row_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (row_waddr[BANK_AW+1:2]),
      .wdata_i (item_a_q.rbyte),
      .raddr_i (ea[BANK_AW+1:2]),
      .rdata_o (bank_rd[b])
    );
  end

  // stage c: row bytes arrive, palette address goes out
  logic                  vld_c_q;
  item_t                 item_c_q;
  logic [ROW_BANKS-1:0]  ok_c_q;
  logic [1:0]            lo_c_q;
  logic                  nib_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else begin
      vld_c_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    item_c_q <= item_a_q;
    ok_c_q   <= rd_ok;
    lo_c_q   <= addr_a_q[1:0];
    nib_c_q  <= nib_a_q;
  end

  logic [BYTE_W-1:0]  bank_byte [ROW_BANKS];
  logic [BYTE_W-1:0]  src_byte  [ROW_BANKS];
  logic [BYTE_W-1:0]  pal_idx;
  logic               pal_ok;
  logic [PAL_AW-1:0]  pal_raddr;
  logic [WORD_W-1:0]  direct_d;
  logic               pal_we;

  always_comb begin
    for (int b = 0; b < ROW_BANKS; b++) begin
      // bytes past the end of the row store read as zero
      bank_byte[b] = ok_c_q[b] ? bank_rd[b] : '0;
    end
    for (int k = 0; k < ROW_BANKS; k++) begin
      src_byte[k] = bank_byte[2'(lo_c_q + 2'(k))];
    end

    if (fmt_i == FMT_4BPP) begin
      pal_idx = nib_c_q ? (src_byte[0] & NIBBLE_MASK) : (src_byte[0] >> 4);
    end else begin
      pal_idx = src_byte[0];
    end
    pal_ok    = ({1'b0, pal_idx} < pal_colors_i) && ({1'b0, pal_idx} < PAL_LIMIT);
    pal_raddr = pal_ok ? pal_idx[PAL_AW-1:0] : '0;

    if (fmt_i == FMT_24BPP) begin
      direct_d = OPAQUE | {ALPHA_ZERO, src_byte[2], src_byte[1], src_byte[0]};
    end else begin
      direct_d = fix_alpha({src_byte[3], src_byte[2], src_byte[1], src_byte[0]});
    end
  end

  assign pal_we = vld_c_q && (item_c_q.func == FUNC_PAL_WR) &&
                  ({1'b0, item_c_q.pidx} < PAL_LIMIT);

  logic [WORD_W-1:0] pal_rd;

  bmpc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (item_c_q.pidx[PAL_AW-1:0]),
    .wdata_i (item_c_q.pword),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rd)
  );

  // stage d: palette entry arrives, pick the pixel
  logic               vld_d_q;
  logic [WORD_W-1:0]  direct_d_q;
  logic [X_W-1:0]     x_d_q;
  logic               use_pal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else begin
      vld_d_q <= vld_c_q && (item_c_q.func == FUNC_PIX_REQ);
    end
  end

  always_ff @(posedge clk_i) begin
    direct_d_q <= direct_d;
    x_d_q      <= item_c_q.x;
  end

  assign use_pal    = (fmt_i == FMT_4BPP) || (fmt_i == FMT_8BPP);
  assign res_vld_o  = vld_d_q;
  assign res_o.argb = use_pal ? fix_alpha(pal_rd) : direct_d_q;
  assign res_o.x    = x_d_q;

endmodule

/* hw/rtl/bmpc_ofifo.sv */
module bmpc_ofifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bmpc_pkg::res_t  push_data_i,
  input  logic            pop_i,
  output logic            vld_o,
  output bmpc_pkg::res_t  data_o
);
  import bmpc_pkg::*;

  res_t                 mem_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]  wptr_q, wptr_d;
  logic [OFIFO_AW-1:0]  rptr_q, rptr_d;
  logic [OFIFO_CW-1:0]  cnt_q, cnt_d;
  logic                 do_pop;

  // upstream credit keeps pushes from overrunning the buffer
  assign do_pop = pop_i && vld_o;

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign vld_o  = cnt_q != '0;
  assign data_o = mem_q[rptr_q];

endmodule

/* hw/rtl/bmp_row_to_argb_converter_top.sv */
// path: a pixel request passes the entry stage, the divider, fetch stages a, c and d and the output buffer
// throughput: one beat per cycle; the 12-stage radix-4 divider and the banked
// row store keep one request per clock, and input stalls once 32 pixel
// results are in flight or waiting in the output buffer
// reset: async active low, clears control and config (format 32 bpp, widths 1,
// 256 palette colors); palette and row store hold garbage until written
module bmp_row_to_argb_converter_top #(
  parameter int MAX_ROW_BYTES = 8192,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bmpc_pkg::FUNC_W-1:0]     func_i,
  input  logic [bmpc_pkg::PIDX_W-1:0]     palette_index_i,
  input  logic [bmpc_pkg::WORD_W-1:0]     palette_word_i,
  input  logic [bmpc_pkg::RADDR_W-1:0]    row_byte_addr_i,
  input  logic [bmpc_pkg::BYTE_W-1:0]     row_byte_i,
  input  logic [bmpc_pkg::X_W-1:0]        target_x_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bmpc_pkg::WORD_W-1:0]     pixel_argb_o,
  output logic [bmpc_pkg::X_W-1:0]        pixel_x_o,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bmpc_pkg::PADDR_W-1:0]    paddr,
  input  logic [bmpc_pkg::PDATA_W-1:0]    pwdata,
  output logic [bmpc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import bmpc_pkg::*;

  // config registers
  fmt_e               fmt_q, fmt_d;
  logic [SW_W-1:0]    sw_q, sw_d;
  logic [SW_W-1:0]    tw_q, tw_d;
  logic [PCOL_W-1:0]  pcol_q, pcol_d;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    fmt_d  = fmt_q;
    sw_d   = sw_q;
    tw_d   = tw_q;
    pcol_d = pcol_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FORMAT:     fmt_d  = fmt_e'(pwdata[FMT_W-1:0]);
        REG_SRC_WIDTH:  sw_d   = pwdata[SW_W-1:0];
        REG_DST_WIDTH:  tw_d   = pwdata[SW_W-1:0];
        REG_PAL_COLORS: pcol_d = pwdata[PCOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FORMAT:     prdata = PDATA_W'(fmt_q);
      REG_SRC_WIDTH:  prdata = PDATA_W'(sw_q);
      REG_DST_WIDTH:  prdata = PDATA_W'(tw_q);
      REG_PAL_COLORS: prdata = PDATA_W'(pcol_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FMT_32BPP;
      sw_q   <= SW_W'(1);
      tw_q   <= SW_W'(1);
      pcol_q <= PCOL_W'(256);
    end else begin
      fmt_q  <= fmt_d;
      sw_q   <= sw_d;
      tw_q   <= tw_d;
      pcol_q <= pcol_d;
    end
  end

  // credit for results in flight plus results buffered
  logic [OFIFO_CW-1:0]  cred_q, cred_d;
  logic                 in_acc;
  logic                 out_acc;
  logic                 take_cred;

  assign in_stall_o = cred_q == OFIFO_CW'(OFIFO_DEPTH);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign take_cred  = in_acc && (func_i == FUNC_PIX_REQ);

  always_comb begin
    cred_d = cred_q;
    if (take_cred && !out_acc) begin
      cred_d = cred_q + 1'b1;
    end else if (!take_cred && out_acc) begin
      cred_d = cred_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
    end else begin
      cred_q <= cred_d;
    end
  end

  // entry stage: capture the beat and form x * source_width
  item_t               in_item;
  logic                vld0_q;
  item_t               item0_q;
  logic [PROD_W-1:0]   prod0_q;
  logic [SW_W-1:0]     divisor;

  assign in_item.func  = func_e'(func_i);
  assign in_item.pidx  = palette_index_i;
  assign in_item.pword = palette_word_i;
  assign in_item.raddr = row_byte_addr_i;
  assign in_item.rbyte = row_byte_i;
  assign in_item.x     = target_x_i;

  // a zero target width divides as one
  assign divisor = (tw_q == '0) ? SW_W'(1) : tw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    item0_q <= in_item;
    prod0_q <= PROD_W'(target_x_i) * PROD_W'(sw_q);
  end

  logic               div_vld;
  item_t              div_item;
  logic [DIV_W-1:0]   div_quot;

  bmpc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (vld0_q),
    .item_i    (item0_q),
    .prod_i    (prod0_q),
    .divisor_i (divisor),
    .vld_o     (div_vld),
    .item_o    (div_item),
    .quot_o    (div_quot)
  );

  logic  res_vld;
  res_t  res;

  bmpc_fetch #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_fetch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (div_vld),
    .item_i       (div_item),
    .sx_i         (div_quot),
    .fmt_i        (fmt_q),
    .pal_colors_i (pcol_q),
    .res_vld_o    (res_vld),
    .res_o        (res)
  );

  res_t  out_res;

  bmpc_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .pop_i       (!out_stall_i),
    .vld_o       (out_valid_o),
    .data_o      (out_res)
  );

  assign pixel_argb_o = out_res.argb;
  assign pixel_x_o    = out_res.x;

endmodule

/* tb/sv/bmp_row_to_argb_converter_top_tb.sv */
module bmp_row_to_argb_converter_top_tb;
  import bmpc_pkg::*;

  localparam int MAX_ROW_BYTES  = 8192;
  localparam int PALETTE_DEPTH  = 256;
  localparam int ITEM_GOAL      = 550;
  localparam int PHASE_BEATS    = 60;
  localparam int QUIET_BEATS    = 80;
  localparam int HOLD_PIXELS    = 48;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LIMIT_CYCLES   = 300000;
  localparam int MAX_PRINTED    = 40;

  // func code the block must drop without a result
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  class argb_pixel_scoreboard;
    logic [WORD_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [BYTE_W-1:0] row_mem [MAX_ROW_BYTES];
    fmt_e              fmt;
    logic [SW_W-1:0]   src_w;
    logic [SW_W-1:0]   dst_w;
    logic [PCOL_W-1:0] colors;
    res_t              expected_pixels [$];
    int                errors;
    int                pixels_checked;
    int                fmt_hits [4];

    function new();
      fmt    = FMT_32BPP;
      src_w  = SW_W'(1);
      dst_w  = SW_W'(1);
      colors = PCOL_W'(256);
    endfunction

    task report_error(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
    endtask

    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_FORMAT:     fmt = fmt_e'(val[FMT_W-1:0]);
        REG_SRC_WIDTH:  src_w = val[SW_W-1:0];
        REG_DST_WIDTH:  dst_w = val[SW_W-1:0];
        REG_PAL_COLORS: colors = val[PCOL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PROD_W-1:0] source_col(logic [X_W-1:0] x);
      logic [PROD_W-1:0] prod;
      logic [SW_W-1:0]   div;
      prod = PROD_W'(x) * PROD_W'(src_w);
      div  = (dst_w == '0) ? SW_W'(1) : dst_w;
      return prod / PROD_W'(div);
    endfunction

    // first row byte of the source pixel and how many bytes it spans
    function void byte_span(input logic [X_W-1:0] x, output logic [ADDR_W-1:0] base,
                            output int nbytes);
      logic [ADDR_W-1:0] sx;
      sx = ADDR_W'(source_col(x));
      case (fmt)
        FMT_4BPP: begin
          base = sx >> 1;
          nbytes = 1;
        end
        FMT_8BPP: begin
          base = sx;
          nbytes = 1;
        end
        FMT_24BPP: begin
          base = (sx << 1) + sx;
          nbytes = 3;
        end
        default: begin
          base = sx << 2;
          nbytes = 4;
        end
      endcase
    endfunction

    function logic [BYTE_W-1:0] row_at(logic [ADDR_W-1:0] a);
      if (a >= ADDR_W'(MAX_ROW_BYTES)) return '0;
      return row_mem[a[RADDR_W-1:0]];
    endfunction

    // palette entry actually read for a packed index byte
    function logic [PIDX_W-1:0] palette_slot(logic [BYTE_W-1:0] b, logic [PROD_W-1:0] sx);
      logic [BYTE_W-1:0] idx;
      if (fmt == FMT_4BPP) idx = sx[0] ? (b & NIBBLE_MASK) : (b >> 4);
      else idx = b;
      if ({1'b0, idx} >= colors) idx = '0;
      return idx;
    endfunction

    function logic [WORD_W-1:0] alpha_default(logic [WORD_W-1:0] w);
      return (w[31:24] == 8'h00) ? (w | OPAQUE) : w;
    endfunction

    function res_t predict_pixel(logic [X_W-1:0] x);
      logic [ADDR_W-1:0] base;
      int                nb;
      res_t              r;
      byte_span(x, base, nb);
      case (fmt)
        FMT_4BPP, FMT_8BPP:
          r.argb = alpha_default(pal_mem[palette_slot(row_at(base), source_col(x))]);
        FMT_24BPP:
          r.argb = OPAQUE | {8'h00, row_at(base + 26'd2), row_at(base + 26'd1), row_at(base)};
        default:
          r.argb = alpha_default({row_at(base + 26'd3), row_at(base + 26'd2),
                                  row_at(base + 26'd1), row_at(base)});
      endcase
      r.x = x;
      return r;
    endfunction

    function void note_beat(logic [FUNC_W-1:0] f, logic [PIDX_W-1:0] pi,
                            logic [WORD_W-1:0] pw, logic [RADDR_W-1:0] ra,
                            logic [BYTE_W-1:0] rb, logic [X_W-1:0] x);
      case (f)
        FUNC_PAL_WR: pal_mem[pi] = pw;
        FUNC_ROW_WR: row_mem[ra] = rb;
        FUNC_PIX_REQ: begin
          expected_pixels.push_back(predict_pixel(x));
          fmt_hits[fmt]++;
        end
        default: ;
      endcase
    endfunction

    task check_pixel(logic [WORD_W-1:0] argb, logic [X_W-1:0] x);
      res_t want;
      if (expected_pixels.size() == 0) begin
        report_error($sformatf("pixel x=%0d argb=%08h with no request pending", x, argb));
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (argb !== want.argb)
        report_error($sformatf("x=%0d argb %08h, predicted %08h", want.x, argb, want.argb));
      if (x !== want.x)
        report_error($sformatf("pixel_x %0d, predicted %0d", x, want.x));
    endtask

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i;
  logic [PIDX_W-1:0]   palette_index_i;
  logic [WORD_W-1:0]   palette_word_i;
  logic [RADDR_W-1:0]  row_byte_addr_i;
  logic [BYTE_W-1:0]   row_byte_i;
  logic [X_W-1:0]      target_x_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [WORD_W-1:0]   pixel_argb_o;
  logic [X_W-1:0]      pixel_x_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  argb_pixel_scoreboard pix_sb;

  bit tx_quiet;
  bit rx_quiet;
  bit rx_hold_req;
  int beats_sent;
  int settings_loaded;
  int holds_done;
  int in_stall_cycles;
  int cycle_count;

  // what the stimulus has written so far, so no request reads an empty entry
  logic [BYTE_W-1:0] row_shadow [MAX_ROW_BYTES];
  bit                row_known  [MAX_ROW_BYTES];
  bit                pal_known  [PALETTE_DEPTH];

  bmp_row_to_argb_converter_top #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
               pix_sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && !in_stall_o)
        pix_sb.note_beat(func_i, palette_index_i, palette_word_i, row_byte_addr_i,
                         row_byte_i, target_x_i);
      if (in_valid_i && in_stall_o) in_stall_cycles++;
      if (out_valid_o && !out_stall_i) pix_sb.check_pixel(pixel_argb_o, pixel_x_o);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        holds_done++;
      end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [BYTE_W-1:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    return {random_byte(), random_byte(), random_byte(), random_byte()};
  endfunction

  // mostly columns inside the target row, some anywhere
  function automatic int random_col();
    int span;
    span = (pix_sb.dst_w == '0) ? 1 : int'(pix_sb.dst_w);
    if (span > 2048) span = 2048;
    if ($urandom_range(0, 4) != 0) return int'($urandom_range(0, span - 1));
    return int'($urandom_range(0, 2047));
  endfunction

  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [PIDX_W-1:0] pi,
                           input logic [WORD_W-1:0] pw, input logic [RADDR_W-1:0] ra,
                           input logic [BYTE_W-1:0] rb, input logic [X_W-1:0] x);
    in_valid_i      <= 1'b1;
    func_i          <= f;
    palette_index_i <= pi;
    palette_word_i  <= pw;
    row_byte_addr_i <= ra;
    row_byte_i      <= rb;
    target_x_i      <= x;
    do @(posedge clk_i); while (in_stall_o);
    if (f != FUNC_NOP) beats_sent++;
    if (!tx_quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic put_row_byte(input logic [RADDR_W-1:0] addr, input logic [BYTE_W-1:0] b);
    row_shadow[addr] = b;
    row_known[addr]  = 1'b1;
    send_beat(FUNC_ROW_WR, 8'($urandom), 32'($urandom), addr, b, 11'($urandom));
  endtask

  task automatic put_palette(input logic [PIDX_W-1:0] idx, input logic [WORD_W-1:0] w);
    pal_known[idx] = 1'b1;
    send_beat(FUNC_PAL_WR, idx, w, 13'($urandom), 8'($urandom), 11'($urandom));
  endtask

  task automatic send_nop();
    send_beat(FUNC_NOP, 8'($urandom), 32'($urandom), 13'($urandom), 8'($urandom),
              11'($urandom));
  endtask

  // fills in any row bytes and palette entry the pixel needs, then asks for it
  task automatic request_pixel(input int col);
    logic [X_W-1:0]    x;
    logic [ADDR_W-1:0] base;
    int                nb;
    int                a;
    logic [BYTE_W-1:0] b;
    logic [PIDX_W-1:0] slot;
    x = col[X_W-1:0];
    pix_sb.byte_span(x, base, nb);
    for (int k = 0; k < nb; k++) begin
      a = int'(base) + k;
      if (a < MAX_ROW_BYTES && !row_known[a]) put_row_byte(RADDR_W'(a), random_byte());
    end
    if (pix_sb.fmt == FMT_4BPP || pix_sb.fmt == FMT_8BPP) begin
      b = (int'(base) < MAX_ROW_BYTES) ? row_shadow[base[RADDR_W-1:0]] : '0;
      slot = pix_sb.palette_slot(b, pix_sb.source_col(x));
      if (!pal_known[slot]) put_palette(slot, random_word());
    end
    send_beat(FUNC_PIX_REQ, 8'($urandom), 32'($urandom), 13'($urandom), 8'($urandom), x);
  endtask

  task automatic apb_write(input logic [1:0] reg_idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pix_sb.set_reg(reg_idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // settings change only once every pixel is out and the pipe has emptied
  task automatic load_settings(input fmt_e f, input int sw, input int tw, input int pc);
    in_valid_i <= 1'b0;
    // let the monitor log the last accepted beat before looking at the queue
    @(posedge clk_i);
    while (pix_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_write(REG_FORMAT, PDATA_W'(f));
    apb_write(REG_SRC_WIDTH, PDATA_W'(sw));
    apb_write(REG_DST_WIDTH, PDATA_W'(tw));
    apb_write(REG_PAL_COLORS, PDATA_W'(pc));
    settings_loaded++;
  endtask

  task automatic load_random_settings();
    fmt_e f;
    int   sw;
    int   tw;
    int   pc;
    f = fmt_e'(2'($urandom));
    case ($urandom_range(0, 3))
      0: sw = 2048;
      1: sw = int'($urandom_range(1, 16));
      default: sw = int'($urandom_range(1, 2048));
    endcase
    case ($urandom_range(0, 7))
      0: tw = 0;
      1: tw = int'($urandom_range(1, 2048));
      2: tw = sw;
      default: tw = int'($urandom_range(1, sw));
    endcase
    case ($urandom_range(0, 4))
      0: pc = 0;
      1: pc = 256;
      2: pc = 16;
      3: pc = 1;
      default: pc = int'($urandom_range(0, 256));
    endcase
    load_settings(f, sw, tw, pc);
  endtask

  task automatic random_action();
    int r;
    int start;
    int run;
    r = int'($urandom_range(0, 99));
    if (r < 12) begin
      put_palette(8'($urandom), random_word());
    end else if (r < 24) begin
      put_row_byte(13'($urandom), random_byte());
    end else if (r < 27) begin
      send_nop();
    end else if (r < 40) begin
      // short left-to-right scan, as a display feed would issue
      start = random_col();
      run = int'($urandom_range(4, 12));
      for (int i = 0; i < run; i++) request_pixel(start + i);
    end else begin
      request_pixel(random_col());
    end
  endtask

  initial begin
    int phase_end;
    pix_sb          = new();
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    func_i          <= FUNC_PAL_WR;
    palette_index_i <= '0;
    palette_word_i  <= '0;
    row_byte_addr_i <= '0;
    row_byte_i      <= '0;
    target_x_i      <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 32 bpp, 1:1; zero alpha turns opaque, last row word
    put_row_byte(13'd0, 8'h12);
    put_row_byte(13'd1, 8'h34);
    put_row_byte(13'd2, 8'h56);
    put_row_byte(13'd3, 8'h00);
    request_pixel(0);
    request_pixel(2047);
    send_nop();

    // 24 bpp, widest scale-down; far columns read past the row store
    load_settings(FMT_24BPP, 2048, 1, 256);
    request_pixel(0);
    request_pixel(1);
    request_pixel(2047);

    // 4 bpp with no valid colors: every index falls back to entry 0
    load_settings(FMT_4BPP, 2048, 2048, 0);
    put_palette(8'd0, 32'h00A0_B0C0);
    put_palette(8'd255, 32'hFFFF_FFFF);
    request_pixel(4);
    request_pixel(7);

    // 8 bpp with target width 0, which acts as 1
    load_settings(FMT_8BPP, 256, 0, 256);
    put_row_byte(13'd256, 8'hFF);
    request_pixel(1);
    request_pixel(2047);

    for (int ph = 0; beats_sent < ITEM_GOAL; ph++) begin
      if (beats_sent >= ITEM_GOAL - QUIET_BEATS) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      case (ph)
        0: load_settings(FMT_32BPP, 2048, 2048, 256);
        1: load_settings(FMT_4BPP, 2048, 1, 16);
        2: load_settings(FMT_32BPP, 1024, 512, 256);
        default: load_random_settings();
      endcase
      if (ph == 2) begin
        // receiver holds off while a scan of the first 48 columns streams in, so the block backs up
        tx_quiet = 1'b1;
        rx_hold_req = 1'b1;
        for (int i = 0; i < HOLD_PIXELS; i++) request_pixel(i);
        tx_quiet = 1'b0;
      end
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) random_action();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pix_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d beats over %0d register settings, %0d pixels checked",
             beats_sent, settings_loaded, pix_sb.pixels_checked);
    $display("pixels by format 4/8/24/32 bpp: %0d/%0d/%0d/%0d; %0d long hold-offs, %s",
             pix_sb.fmt_hits[0], pix_sb.fmt_hits[1], pix_sb.fmt_hits[2], pix_sb.fmt_hits[3],
             holds_done, $sformatf("%0d input stall cycles", in_stall_cycles));
    if (pix_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", pix_sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* bmp_row_to_argb_converter_top.f */
hw/rtl/bmpc_pkg.sv
hw/rtl/bmpc_ram.sv
hw/rtl/bmpc_div.sv
hw/rtl/bmpc_fetch.sv
hw/rtl/bmpc_ofifo.sv
hw/rtl/bmp_row_to_argb_converter_top.sv
tb/sv/bmp_row_to_argb_converter_top_tb.sv
